@@ design/rotary_knob_button_event_qualifier_unit_defines.svh @@
// Assertion macros shared by the checker of the rotary knob event qualifier.
// Depends on nothing; include by bare file name.
`ifndef ROTARY_KNOB_BUTTON_EVENT_QUALIFIER_UNIT_DEFINES_SVH
`define ROTARY_KNOB_BUTTON_EVENT_QUALIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define RKBEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rkbeq assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define RKBEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rkbeq assertion failed");

`endif

@@ design/rkbeq_pkg.sv @@
// Types and constants for the rotary knob / button event qualifier.
// No dependencies.
`timescale 1ns / 1ps

package rkbeq_pkg;

  // Item operations
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_EDGE  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Queued event codes
  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_CW   = 3'd1,
    EV_CCW  = 3'd2,
    EV_DOWN = 3'd3,
    EV_UP   = 3'd4,
    EV_LONG = 3'd5
  } evt_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_ENC_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BTN_DEBOUNCE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS   = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers
  localparam logic [CfgDataW-1:0] ENC_DEBOUNCE_RST = 16'd2;
  localparam logic [CfgDataW-1:0] BTN_DEBOUNCE_RST = 16'd30;
  localparam logic [CfgDataW-1:0] LONG_PRESS_RST   = 16'd1000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic        phase_b_high;
    logic        button_pressed;
  } item_t;

  typedef struct packed {
    logic [2:0]         event_code;
    logic signed [31:0] rotation_count;
  } result_t;

endpackage

@@ design/rkbeq_stream_if.sv @@
// Valid/ready stream channel carrying one payload per beat.
// Payload type is supplied by the instantiating level (see rkbeq_pkg).
`timescale 1ns / 1ps

interface rkbeq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/rotary_knob_button_event_qualifier_unit.sv @@
// Rotary encoder and push-button event qualifier with a ring event queue.
// Latency: result beat is valid the cycle after the item beat is accepted.
// Throughput: one item per cycle unless the result stalls; output register and
//   the registered ring read set this; the memory port is the only shared unit.
// Reset: rst_ni async active low clears pointers, count, button machine and
//   config to defaults; queue memory contents need no reset (never read empty).
`timescale 1ns / 1ps

module rotary_knob_button_event_qualifier_unit
  import rkbeq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rkbeq_stream_if.sink        item_i,
  rkbeq_stream_if.source      result_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DDOWN = 2'd1,
    PH_HELD  = 2'd2,
    PH_DUP   = 2'd3
  } phase_e;

  // Config registers
  logic [CfgDataW-1:0] enc_db_q, btn_db_q, long_ms_q;

  // Scalar state
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [31:0]     rot_q, rot_d;
  logic [31:0]     last_edge_q, last_edge_d;
  phase_e          phase_q, phase_d;
  logic [31:0]     phase_start_q, phase_start_d;
  logic [31:0]     press_start_q, press_start_d;
  logic            long_rep_q, long_rep_d;

  // Output stage
  logic            out_valid_q;
  logic            hit_q;
  logic [31:0]     rot_out_q;

  // Event memory
  logic [2:0]      ring_mem [QUEUE_DEPTH];
  logic [2:0]      mem_rd_q;

  logic            accept;
  item_t           item;
  logic            push_req, push_ok, pop_hit;
  evt_e            push_code;
  logic [PtrW-1:0] wr_ptr_inc, rd_ptr_inc;
  logic [31:0]     edge_diff, phase_diff, press_diff;

  assign item         = item_i.payload;
  assign item_i.ready = !out_valid_q || result_o.ready;
  assign accept       = item_i.valid && item_i.ready;

  assign wr_ptr_inc = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;

  // Elapsed times, wrap modulo 2^32
  assign edge_diff  = item.now_ms - last_edge_q;
  assign phase_diff = item.now_ms - phase_start_q;
  assign press_diff = item.now_ms - press_start_q;

  // Per-item state update
  always_comb begin
    rot_d         = rot_q;
    last_edge_d   = last_edge_q;
    phase_d       = phase_q;
    phase_start_d = phase_start_q;
    press_start_d = press_start_q;
    long_rep_d    = long_rep_q;
    rd_ptr_d      = rd_ptr_q;
    push_req      = 1'b0;
    push_code     = EV_NONE;
    pop_hit       = 1'b0;
    if (accept) begin
      unique case (op_e'(item.operation))
        OP_POLL: begin
          unique case (phase_q)
            PH_IDLE: begin
              if (item.button_pressed) begin
                phase_d       = PH_DDOWN;
                phase_start_d = item.now_ms;
              end
            end
            PH_DDOWN: begin
              if (!item.button_pressed) begin
                phase_d = PH_IDLE;
              end else if (phase_diff >= {16'd0, btn_db_q}) begin
                phase_d       = PH_HELD;
                press_start_d = item.now_ms;
                long_rep_d    = 1'b0;
                push_req      = 1'b1;
                push_code     = EV_DOWN;
              end
            end
            PH_HELD: begin
              if (!item.button_pressed) begin
                phase_d       = PH_DUP;
                phase_start_d = item.now_ms;
              end else if (!long_rep_q && press_diff >= {16'd0, long_ms_q}) begin
                long_rep_d = 1'b1;
                push_req   = 1'b1;
                push_code  = EV_LONG;
              end
            end
            PH_DUP: begin
              if (item.button_pressed) begin
                phase_d = PH_HELD;
              end else if (phase_diff >= {16'd0, btn_db_q}) begin
                phase_d   = PH_IDLE;
                push_req  = 1'b1;
                push_code = EV_UP;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end
        OP_EDGE: begin
          if (edge_diff >= {16'd0, enc_db_q}) begin
            last_edge_d = item.now_ms;
            push_req    = 1'b1;
            if (item.phase_b_high) begin
              rot_d     = rot_q + 32'd1;
              push_code = EV_CW;
            end else begin
              rot_d     = rot_q - 32'd1;
              push_code = EV_CCW;
            end
          end
        end
        OP_POP: begin
          if (rd_ptr_q != wr_ptr_q) begin
            pop_hit  = 1'b1;
            rd_ptr_d = rd_ptr_inc;
          end
        end
        OP_CLEAR: rot_d = '0;
        default: rot_d = rot_q;
      endcase
    end
  end

  // Drop the event when the ring is full
  assign push_ok  = push_req && (wr_ptr_inc != rd_ptr_q);
  assign wr_ptr_d = push_ok ? wr_ptr_inc : wr_ptr_q;

  // Event ring: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      ring_mem[wr_ptr_q] <= push_code;
    end
    if (pop_hit) begin
      mem_rd_q <= ring_mem[rd_ptr_q];
    end
  end

  // Config writes; unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_db_q  <= ENC_DEBOUNCE_RST;
      btn_db_q  <= BTN_DEBOUNCE_RST;
      long_ms_q <= LONG_PRESS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ENC_DEBOUNCE) enc_db_q  <= cfg_data_i;
      if (cfg_idx_i == REG_BTN_DEBOUNCE) btn_db_q  <= cfg_data_i;
      if (cfg_idx_i == REG_LONG_PRESS)   long_ms_q <= cfg_data_i;
    end
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      rot_q         <= '0;
      last_edge_q   <= '0;
      phase_q       <= PH_IDLE;
      phase_start_q <= '0;
      press_start_q <= '0;
      long_rep_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      hit_q         <= 1'b0;
    end else begin
      rd_ptr_q      <= rd_ptr_d;
      wr_ptr_q      <= wr_ptr_d;
      rot_q         <= rot_d;
      last_edge_q   <= last_edge_d;
      phase_q       <= phase_d;
      phase_start_q <= phase_start_d;
      press_start_q <= press_start_d;
      long_rep_q    <= long_rep_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        hit_q       <= pop_hit;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Count travels with the beat; payload register needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rot_out_q <= rot_d;
    end
  end

  assign result_o.valid                  = out_valid_q;
  assign result_o.payload.event_code     = hit_q ? mem_rd_q : EV_NONE;
  assign result_o.payload.rotation_count = signed'(rot_out_q);

endmodule

@@ design/rkbeq_checker.sv @@
// Port-level checker for the rotary knob event qualifier, bound to the top.
// Depends on rkbeq_pkg and the defines header.
`timescale 1ns / 1ps
`include "rotary_knob_button_event_qualifier_unit_defines.svh"

module rkbeq_checker
  import rkbeq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic [1:0]         in_op_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [2:0]         out_code_i,
  input logic signed [31:0] out_count_i
);

  logic in_beat;
  logic out_stall;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // A stalled result beat stays up
  `RKBEQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i)
  // Every accepted item yields a result in the next cycle
  `RKBEQ_ASSERT_NEXT(a_in_to_out, clk_i, rst_ni, in_beat, out_valid_i)
  // A new result beat only follows an accepted item
  `RKBEQ_ASSERT_NOW(a_no_orphan, clk_i, rst_ni, out_valid_i && !$past(out_stall), $past(in_beat))
  // Only defined event codes come out
  `RKBEQ_ASSERT_NOW(a_code_range, clk_i, rst_ni, out_valid_i, out_code_i <= EV_LONG)
  // Clearing gives a zero count and no popped event
  `RKBEQ_ASSERT_NEXT(a_clear_zero, clk_i, rst_ni, in_beat && (in_op_i == OP_CLEAR),
                     (out_count_i == 32'sd0) && (out_code_i == EV_NONE))

endmodule

bind rotary_knob_button_event_qualifier_unit rkbeq_checker u_rkbeq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .in_op_i     (item_i.payload.operation),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_code_i  (result_o.payload.event_code),
  .out_count_i (result_o.payload.rotation_count)
);

@@ bench/knob_event_checker.sv @@
// Checker for the rotary knob / button event qualifier: mirrors register writes,
// predicts each result beat from the accepted item beats and compares them.
// Depends on rkbeq_pkg for the item, result, event and register definitions.
`timescale 1ns / 1ps

module knob_event_checker
  import rkbeq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                item_valid_i,
  input  logic                item_ready_i,
  input  item_t               item_i,
  input  logic                result_valid_i,
  input  logic                result_ready_i,
  input  result_t             result_i,
  output int unsigned         fail_count_o,
  output int unsigned         expected_left_o,
  output int unsigned         results_checked_o
);

  localparam int unsigned MaxPrinted = 50;

  typedef enum logic [1:0] {
    BTN_IDLE      = 2'd0,
    BTN_WAIT_DOWN = 2'd1,
    BTN_HELD      = 2'd2,
    BTN_WAIT_UP   = 2'd3
  } btn_phase_e;

  // Mirrored registers
  logic [CfgDataW-1:0] enc_db_ms;
  logic [CfgDataW-1:0] btn_db_ms;
  logic [CfgDataW-1:0] long_ms;

  // Knob / button state
  evt_e               event_ring [QUEUE_DEPTH];
  int unsigned        rd_ptr;
  int unsigned        wr_ptr;
  logic signed [31:0] rotation;
  logic [31:0]        last_edge_ms;
  btn_phase_e         btn_phase;
  logic [31:0]        phase_start_ms;
  logic [31:0]        press_start_ms;
  logic               long_done;

  result_t     pending_results [$];
  int unsigned mismatches;
  int unsigned checked;

  task automatic reset_knob_state();
    enc_db_ms      = ENC_DEBOUNCE_RST;
    btn_db_ms      = BTN_DEBOUNCE_RST;
    long_ms        = LONG_PRESS_RST;
    for (int i = 0; i < QUEUE_DEPTH; i++) event_ring[i] = EV_NONE;
    rd_ptr         = 0;
    wr_ptr         = 0;
    rotation       = '0;
    last_edge_ms   = '0;
    btn_phase      = BTN_IDLE;
    phase_start_ms = '0;
    press_start_ms = '0;
    long_done      = 1'b0;
  endtask

  // Ring keeps one slot free; a push into a full ring is lost
  task automatic queue_event(input evt_e code);
    int unsigned nxt;
    nxt = (wr_ptr + 1) % QUEUE_DEPTH;
    if (nxt != rd_ptr) begin
      event_ring[wr_ptr] = code;
      wr_ptr = nxt;
    end
  endtask

  task automatic step_button(input logic [31:0] now, input logic down);
    case (btn_phase)
      BTN_IDLE: begin
        if (down) begin
          btn_phase      = BTN_WAIT_DOWN;
          phase_start_ms = now;
        end
      end
      BTN_WAIT_DOWN: begin
        if (!down) begin
          btn_phase = BTN_IDLE;
        end else if (now - phase_start_ms >= {16'd0, btn_db_ms}) begin
          btn_phase      = BTN_HELD;
          press_start_ms = now;
          long_done      = 1'b0;
          queue_event(EV_DOWN);
        end
      end
      BTN_HELD: begin
        if (!down) begin
          btn_phase      = BTN_WAIT_UP;
          phase_start_ms = now;
        end else if (!long_done && (now - press_start_ms >= {16'd0, long_ms})) begin
          long_done = 1'b1;
          queue_event(EV_LONG);
        end
      end
      default: begin
        if (down) begin
          btn_phase = BTN_HELD;
        end else if (now - phase_start_ms >= {16'd0, btn_db_ms}) begin
          btn_phase = BTN_IDLE;
          queue_event(EV_UP);
        end
      end
    endcase
  endtask

  // Apply one item beat to the state and build the result it yields
  task automatic predict_knob_result(input item_t it, output result_t res);
    evt_e code;
    code = EV_NONE;
    case (op_e'(it.operation))
      OP_POLL: step_button(it.now_ms, it.button_pressed);
      OP_EDGE: begin
        if (it.now_ms - last_edge_ms >= {16'd0, enc_db_ms}) begin
          last_edge_ms = it.now_ms;
          if (it.phase_b_high) begin
            rotation = rotation + 32'sd1;
            queue_event(EV_CW);
          end else begin
            rotation = rotation - 32'sd1;
            queue_event(EV_CCW);
          end
        end
      end
      OP_POP: begin
        if (rd_ptr != wr_ptr) begin
          code   = event_ring[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
        end
      end
      default: rotation = '0;
    endcase
    res.event_code     = code;
    res.rotation_count = rotation;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic check_result_beat(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with no item waiting", 32'd0, {29'd0, got.event_code});
    end else begin
      want = pending_results.pop_front();
      checked++;
      if (got.event_code !== want.event_code)
        report_mismatch("event_code", {29'd0, want.event_code}, {29'd0, got.event_code});
      if (got.rotation_count !== want.rotation_count)
        report_mismatch("rotation_count", want.rotation_count, got.rotation_count);
    end
  endtask

  // Results are compared before the item of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_res;
    if (!rst_ni) begin
      reset_knob_state();
      pending_results.delete();
      mismatches = 0;
      checked    = 0;
      fail_count_o      <= 0;
      expected_left_o   <= 0;
      results_checked_o <= 0;
    end else begin
      if (result_valid_i && result_ready_i) check_result_beat(result_i);
      if (item_valid_i && item_ready_i) begin
        predict_knob_result(item_i, exp_res);
        pending_results.push_back(exp_res);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENC_DEBOUNCE: enc_db_ms = cfg_data_i;
          REG_BTN_DEBOUNCE: btn_db_ms = cfg_data_i;
          REG_LONG_PRESS:   long_ms   = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o      <= mismatches;
      expected_left_o   <= pending_results.size();
      results_checked_o <= checked;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the knob / button event qualifier bench: clock, reset, register writes,
// item stimulus and result back-pressure, watchdog and verdict.
// Depends on rkbeq_pkg, rkbeq_stream_if, knob_event_checker and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import rkbeq_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 16;
  localparam int unsigned ITEMS_PER_PHASE = 275;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  rkbeq_stream_if #(.payload_t(item_t))   item_ch ();
  rkbeq_stream_if #(.payload_t(result_t)) result_ch ();

  int unsigned fail_count;
  int unsigned expected_left;
  int unsigned results_checked;

  // Stimulus bookkeeping
  logic        item_taken_q;
  logic [31:0] clock_ms;
  int unsigned cur_enc, cur_btn, cur_long;
  int unsigned items_sent;
  int unsigned settings_used;
  bit          sender_gaps;
  bit          receiver_stalls;
  bit          quiet_tail;
  int unsigned stall_left;
  int unsigned idle_cycles;

  rotary_knob_button_event_qualifier_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .item_i    (item_ch),
    .result_o  (result_ch)
  );

  knob_event_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .item_valid_i     (item_ch.valid),
    .item_ready_i     (item_ch.ready),
    .item_i           (item_ch.payload),
    .result_valid_i   (result_ch.valid),
    .result_ready_i   (result_ch.ready),
    .result_i         (result_ch.payload),
    .fail_count_o     (fail_count),
    .expected_left_o  (expected_left),
    .results_checked_o(results_checked)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Item beat taken at the last rising edge; read at the falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_taken_q <= 1'b0;
    end else begin
      item_taken_q <= item_ch.valid && item_ch.ready;
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result back-pressure in bursts
  initial begin
    result_ch.ready = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail || !receiver_stalls) begin
        result_ch.ready = 1'b1;
        stall_left      = 0;
      end else if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 6) == 0) begin
        result_ch.ready = 1'b0;
        stall_left      = $urandom_range(1, 9) - 1;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_item(input op_e op, input logic [31:0] ms, input logic b_high,
                           input logic pressed);
    int unsigned gap;
    if (sender_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
      item_ch.valid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk_i);
    end
    item_ch.payload.operation      = op;
    item_ch.payload.now_ms         = ms;
    item_ch.payload.phase_b_high   = b_high;
    item_ch.payload.button_pressed = pressed;
    item_ch.valid = 1'b1;
    do @(negedge clk_i); while (!item_taken_q);
    items_sent++;
  endtask

  task automatic tick_ms(input int unsigned span);
    clock_ms = clock_ms + 32'($urandom_range(0, span));
  endtask

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Hold off items until every result beat is back
  task automatic drain_results();
    item_ch.valid = 1'b0;
    while (expected_left != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_idx  = idx;
    cfg_data = val;
    cfg_we   = 1'b1;
    @(negedge clk_i);
    case (idx)
      REG_ENC_DEBOUNCE: cur_enc  = val;
      REG_BTN_DEBOUNCE: cur_btn  = val;
      REG_LONG_PRESS:   cur_long = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] enc, input logic [CfgDataW-1:0] btn,
                               input logic [CfgDataW-1:0] lng);
    drain_results();
    write_reg(REG_ENC_DEBOUNCE, enc);
    write_reg(REG_BTN_DEBOUNCE, btn);
    write_reg(REG_LONG_PRESS, lng);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  // Press with bounces, hold (maybe long), release with bounces, stay released
  task automatic press_sequence();
    int unsigned span_db, span_hold, n;
    span_db   = cur_btn / 3 + 2;
    span_hold = (cur_long + cur_btn) / 4 + 3;
    n = $urandom_range(0, 3);
    repeat (n) begin
      tick_ms(span_db);
      send_item(OP_POLL, clock_ms, coin(), coin());
    end
    n = $urandom_range(2, 12);
    repeat (n) begin
      tick_ms(span_hold);
      send_item(OP_POLL, clock_ms, coin(), 1'b1);
      if ($urandom_range(0, 7) == 0) begin
        tick_ms(cur_enc + 2);
        send_item(OP_EDGE, clock_ms, coin(), coin());
      end
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      tick_ms(span_db);
      send_item(OP_POLL, clock_ms, coin(), coin());
    end
    n = $urandom_range(2, 5);
    repeat (n) begin
      tick_ms(span_hold);
      send_item(OP_POLL, clock_ms, coin(), 1'b0);
    end
  endtask

  task automatic edge_burst();
    int unsigned n;
    n = $urandom_range(1, 20);
    repeat (n) begin
      tick_ms(cur_enc * 2 + 2);
      send_item(OP_EDGE, clock_ms, coin(), coin());
    end
  endtask

  task automatic pop_burst();
    int unsigned n;
    n = $urandom_range(1, 20);
    repeat (n) send_item(OP_POP, clock_ms, coin(), coin());
  endtask

  // Arbitrary items, including full-range timestamps and time jumps
  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) clock_ms = $urandom();
      send_item(op_e'($urandom_range(0, 3)),
                ($urandom_range(0, 1) == 0) ? $urandom() : clock_ms, coin(), coin());
    end
  endtask

  // Defaults: bounce rejection, long press, queue order, timestamp wrap
  task automatic directed_items();
    send_item(OP_POP,   32'd0, 1'b0, 1'b0);   // empty queue
    send_item(OP_EDGE,  32'd0, 1'b1, 1'b0);   // inside encoder window
    send_item(OP_EDGE,  32'd2, 1'b1, 1'b0);   // cw
    send_item(OP_EDGE,  32'd3, 1'b0, 1'b0);   // too close
    send_item(OP_EDGE,  32'd4, 1'b0, 1'b0);   // ccw
    send_item(OP_CLEAR, 32'd5, 1'b1, 1'b1);
    send_item(OP_POLL,  32'd10, 1'b0, 1'b1);
    send_item(OP_POLL,  32'd20, 1'b0, 1'b0);  // bounce back to idle
    send_item(OP_POLL,  32'd30, 1'b0, 1'b1);
    send_item(OP_POLL,  32'd60, 1'b0, 1'b1);  // down
    send_item(OP_POLL,  32'd1060, 1'b0, 1'b1); // long
    send_item(OP_POLL,  32'd2001, 1'b0, 1'b0);
    send_item(OP_POLL,  32'd2005, 1'b0, 1'b1); // release bounce
    send_item(OP_POLL,  32'd2010, 1'b0, 1'b0);
    send_item(OP_POLL,  32'd2040, 1'b0, 1'b0); // up
    send_item(OP_EDGE,  32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(OP_EDGE,  32'd1, 1'b0, 1'b0);   // across the wrap
    repeat (8) send_item(OP_POP, 32'd1, 1'b0, 1'b0);
    clock_ms = 32'd2;
  endtask

  task automatic random_items(input int unsigned target, input bit pause_once);
    int unsigned pick;
    bit paused;
    paused = 1'b0;
    while (items_sent < target) begin
      sender_gaps     = ($urandom_range(0, 3) != 0);
      receiver_stalls = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 40) press_sequence();
      else if (pick < 65) edge_burst();
      else if (pick < 85) pop_burst();
      else if (pick < 96) noise_burst();
      else send_item(OP_CLEAR, clock_ms, coin(), coin());
      if (pause_once && !paused && items_sent + 100 >= target) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_ENC_DEBOUNCE;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    clock_ms        = '0;
    cur_enc         = ENC_DEBOUNCE_RST;
    cur_btn         = BTN_DEBOUNCE_RST;
    cur_long        = LONG_PRESS_RST;
    items_sent      = 0;
    settings_used   = 1;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    quiet_tail      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Unused index must leave the defaults alone
    write_reg(REG_SPARE, 16'($urandom()));
    cfg_we = 1'b0;
    directed_items();
    random_items(ITEMS_PER_PHASE, 1'b1);

    for (int p = 1; p < NUM_PHASES; p++) begin
      case (p)
        1: apply_setting(16'd0, 16'd0, 16'd0);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: apply_setting(16'($urandom_range(0, 8)), 16'($urandom_range(0, 40)),
                         16'($urandom_range(0, 200)));
        4: apply_setting(16'($urandom()), 16'($urandom()), 16'($urandom()));
        default: begin
          apply_setting(16'($urandom_range(1, 4)), 16'($urandom_range(5, 30)),
                        16'($urandom_range(50, 300)));
          quiet_tail = 1'b1;
        end
      endcase
      random_items(ITEMS_PER_PHASE * (p + 1), 1'b0);
    end

    item_ch.valid = 1'b0;
    while (expected_left != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);

    $display("Sent %0d item beats under %0d register settings; %0d result beats checked.",
             items_sent, settings_used, results_checked);
    $display("Stimulus: bounced presses, long holds, edge bursts, queue overflow, wraps.");
    if (fail_count == 0 && expected_left == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_count, expected_left);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/rkbeq_pkg.sv
design/rkbeq_stream_if.sv
design/rotary_knob_button_event_qualifier_unit.sv
design/rkbeq_checker.sv
bench/knob_event_checker.sv
bench/tb_top.sv
